FILE: src/srle_pkg.sv
`default_nettype none

package srle_pkg;

    // One result item as it moves through the queue and the output stage
    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_row_count;
        logic [15:0] image_total;
        logic        row_overflow;
        logic        last;
    } srle_item_t;

    // Up to three result items written into the queue in one cycle
    typedef struct packed {
        logic [1:0]           cnt;
        srle_item_t [2:0]     items;
    } srle_push_t;

    localparam int unsigned QDEPTH   = 8;
    localparam int unsigned QPTR_W   = $clog2(QDEPTH);
    localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);
    localparam int unsigned PUSH_MAX = 3;

    localparam logic [7:0] CNT_BASE   = 8'h80;
    localparam logic [7:0] COLOR_FULL = 8'hFF;
    localparam logic [8:0] BYTES_SAT  = 9'd511;
    localparam logic [8:0] BYTES_BYTE = 9'd255;

    function automatic srle_item_t data_item(input logic [7:0] b);
        srle_item_t it;
        it.out_byte     = b;
        it.is_row_count = 1'b0;
        it.image_total  = 16'd0;
        it.row_overflow = 1'b0;
        it.last         = 1'b0;
        return it;
    endfunction

    // A color with its top bit set, other than full white, needs a count byte
    function automatic logic needs_count(input logic [7:0] color);
        return color[7] && (color != COLOR_FULL);
    endfunction

endpackage

`default_nettype wire

FILE: src/srle_front.sv
`default_nettype none

module srle_front #(
    parameter int MAX_REPEATS = 126
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  accept,
    input  wire  [7:0]           pixel,
    input  wire                  row_end,
    input  wire                  image_start,
    output srle_pkg::srle_push_t push
);

    localparam logic [6:0] MaxRep = 7'(MAX_REPEATS);

    logic [7:0]  run_color_reg,   run_color_next;
    logic [6:0]  run_repeats_reg, run_repeats_next;
    logic        row_started_reg, row_started_next;
    logic [8:0]  row_bytes_reg,   row_bytes_next;
    logic [15:0] total_bytes_reg, total_bytes_next;
    logic [1:0]  held_cnt_reg,    held_cnt_next;
    srle_pkg::srle_item_t held_reg  [0:2];
    srle_pkg::srle_item_t held_next [0:2];

    srle_pkg::srle_item_t list [0:7];
    srle_pkg::srle_item_t cnt_item;
    logic [3:0]  n;
    logic [1:0]  k;
    logic [2:0]  emitted;
    logic [9:0]  bytes_sum;
    logic [8:0]  bytes_sat;
    logic [7:0]  color;
    logic [6:0]  rep;
    logic        started;
    logic [15:0] total;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            list[i] = '0;
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < held_cnt_reg) begin
                list[i] = held_reg[i];
            end
        end
        n        = {2'b00, held_cnt_reg};
        emitted  = 3'd0;
        color    = run_color_reg;
        rep      = run_repeats_reg;
        started  = row_started_reg && !image_start;
        total    = image_start ? 16'd0 : total_bytes_reg;
        cnt_item = '0;

        if (!started) begin
            color = pixel;
            rep   = 7'd0;
        end else if (pixel == color) begin
            if (rep >= MaxRep) begin
                // split a run that has reached its longest count
                list[n[2:0]] = srle_pkg::data_item(srle_pkg::CNT_BASE | {1'b0, rep});
                n = n + 4'd1;
                list[n[2:0]] = srle_pkg::data_item(color);
                n = n + 4'd1;
                emitted = emitted + 3'd2;
                rep = 7'd0;
            end else begin
                rep = rep + 7'd1;
            end
        end else begin
            if (rep != 7'd0 || srle_pkg::needs_count(color)) begin
                list[n[2:0]] = srle_pkg::data_item(srle_pkg::CNT_BASE | {1'b0, rep});
                n = n + 4'd1;
                emitted = emitted + 3'd1;
            end
            list[n[2:0]] = srle_pkg::data_item(color);
            n = n + 4'd1;
            emitted = emitted + 3'd1;
            color = pixel;
            rep   = 7'd0;
        end

        if (row_end) begin
            // flush the open run; the row length item follows it
            if (rep != 7'd0 || srle_pkg::needs_count(color)) begin
                list[n[2:0]] = srle_pkg::data_item(srle_pkg::CNT_BASE | {1'b0, rep});
                n = n + 4'd1;
                emitted = emitted + 3'd1;
            end
            list[n[2:0]] = srle_pkg::data_item(color);
            n = n + 4'd1;
            emitted = emitted + 3'd1;
        end

        bytes_sum = {1'b0, (started ? row_bytes_reg : 9'd0)} + {7'd0, emitted};
        bytes_sat = (bytes_sum > {1'b0, srle_pkg::BYTES_SAT}) ? srle_pkg::BYTES_SAT
                                                               : bytes_sum[8:0];

        if (row_end) begin
            total = total + {8'd0, bytes_sat[7:0]} + 16'd1;
            cnt_item.out_byte     = bytes_sat[7:0];
            cnt_item.is_row_count = 1'b1;
            cnt_item.image_total  = total;
            cnt_item.row_overflow = bytes_sat > srle_pkg::BYTES_BYTE;
            cnt_item.last         = 1'b0;
            list[n[2:0]] = cnt_item;
            n = n + 4'd1;
            started = 1'b0;
            rep     = 7'd0;
            bytes_sat = 9'd0;
        end

        k = (n > 4'd3) ? 2'd3 : n[1:0];

        push.cnt = accept ? k : 2'd0;
        for (int i = 0; i < 3; i++) begin
            push.items[i]      = list[i];
            push.items[i].last = (2'(i) == k - 2'd1);
        end

        for (int i = 0; i < 3; i++) begin
            held_next[i] = list[i + 3];
        end
        held_cnt_next    = (n > 4'd3) ? 2'(n - 4'd3) : 2'd0;
        run_color_next   = color;
        run_repeats_next = rep;
        row_started_next = started || !row_end;
        row_bytes_next   = bytes_sat;
        total_bytes_next = total;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_color_reg   <= 8'd0;
            run_repeats_reg <= 7'd0;
            row_started_reg <= 1'b0;
            row_bytes_reg   <= 9'd0;
            total_bytes_reg <= 16'd0;
            held_cnt_reg    <= 2'd0;
        end else if (accept) begin
            run_color_reg   <= run_color_next;
            run_repeats_reg <= run_repeats_next;
            row_started_reg <= row_started_next;
            row_bytes_reg   <= row_bytes_next;
            total_bytes_reg <= total_bytes_next;
            held_cnt_reg    <= held_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < 3; i++) begin
                held_reg[i] <= held_next[i];
            end
        end
    end

    // leftover results only exist right after a row closed
    a_held_after_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        held_cnt_reg != 2'd0 |-> !row_started_reg)
        else $error("held results while a row is open");

    a_idle_row_no_repeats: assert property (@(posedge aclk) disable iff (!aresetn)
        !row_started_reg |-> (run_repeats_reg == 7'd0 && row_bytes_reg == 9'd0))
        else $error("run state left over outside a row");

    a_repeats_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        run_repeats_reg <= MaxRep)
        else $error("run repeat count beyond its limit");

endmodule

`default_nettype wire

FILE: src/srle_fifo.sv
`default_nettype none

module srle_fifo (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  srle_pkg::srle_push_t  push,
    input  wire                   pop,
    output logic                  space_ok,
    output logic                  head_valid,
    output srle_pkg::srle_item_t  head_item
);

    localparam logic [srle_pkg::QCNT_W-1:0] ReadyLimit =
        srle_pkg::QCNT_W'(srle_pkg::QDEPTH - srle_pkg::PUSH_MAX);

    srle_pkg::srle_item_t q_reg [0:srle_pkg::QDEPTH-1];
    logic [srle_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [srle_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [srle_pkg::QCNT_W-1:0] count_reg,  count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg + srle_pkg::QPTR_W'(push.cnt);
        rd_ptr_next = rd_ptr_reg + srle_pkg::QPTR_W'(pop);
        count_next  = count_reg + srle_pkg::QCNT_W'(push.cnt) - srle_pkg::QCNT_W'(pop);
    end

    assign space_ok   = (count_reg <= ReadyLimit);
    assign head_valid = (count_reg != '0);
    assign head_item  = q_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < push.cnt) begin
                q_reg[wr_ptr_reg + srle_pkg::QPTR_W'(i)] <= push.items[i];
            end
        end
    end

    a_no_overfill: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= srle_pkg::QCNT_W'(srle_pkg::QDEPTH))
        else $error("queue holds more items than its depth");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("pop from an empty queue");

    a_push_needs_space: assert property (@(posedge aclk) disable iff (!aresetn)
        push.cnt != 2'd0 |-> space_ok)
        else $error("push while the queue lacks room for a full burst");

endmodule

`default_nettype wire

FILE: src/srle_out.sv
`default_nettype none

module srle_out (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   head_valid,
    input  srle_pkg::srle_item_t  head_item,
    output logic                  pop,
    input  wire                   out_ready,
    output logic                  out_valid,
    output srle_pkg::srle_item_t  out_item
);

    logic                 valid_reg, valid_next;
    srle_pkg::srle_item_t item_reg;

    // refill the output register whenever the queue has an item and the register is empty or being taken
    assign pop        = head_valid && (!valid_reg || out_ready);
    assign valid_next = pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            item_reg <= head_item;
        end
    end

    a_pop_only_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && !out_ready) |-> !pop)
        else $error("output register overwritten while stalled");

    a_fill_follows_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> valid_reg)
        else $error("popped item did not reach the output register");

    a_empty_stays_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (!valid_reg && !head_valid) |=> !valid_reg)
        else $error("output valid without a queued item");

endmodule

`default_nettype wire

FILE: src/sprite_row_rle_encoder_core.sv
`default_nettype none

// Row-wise run-length encoder for 8-bit palette pixels. Pixels enter one per
// item on the s_ stream; s_tlast marks the last pixel of a row and s_tuser
// the first pixel of a new image. Each run of equal pixels leaves as a count
// byte (0x80 plus repeats) and the color; a lone pixel goes out raw unless
// its top bit is set and it is not 0xFF. After a row's data the block sends
// the row's byte count with m_tuser set, carrying the running image total
// and an overflow flag for rows above 255 bytes. m_tlast marks the last
// result sent with a pixel; a row end can cause more than three results,
// and the extra ones go out with the next pixel, so a pixel may produce none
// of its own. Rate: one pixel per cycle while results average one per pixel
// or fewer and m_tready is high. The classifier writes up to three results
// a cycle into an eight-entry queue, the output register drains one a cycle
// while m_tready is high, so s_tready drops whenever fewer than three queue
// slots are free. A result passes the queue, then the output register.
module sprite_row_rle_encoder_core #(
    parameter int MAX_REPEATS = 126
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [7:0]  s_tdata,   // [7:0] pixel
    input  wire         s_tlast,   // row_end
    input  wire         s_tuser,   // image_start

    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [7:0] out_byte, [23:8] image_total,
                                   // [24] row_overflow, [31:25] zero
    output logic        m_tlast,   // last result sent with its pixel
    output logic        m_tuser    // is_row_count
);

    logic                  accept;
    logic                  space_ok;
    logic                  head_valid;
    logic                  pop;
    srle_pkg::srle_push_t  push;
    srle_pkg::srle_item_t  head_item;
    srle_pkg::srle_item_t  out_item;

    // accept only when the queue can take a full burst from this pixel
    assign s_tready = space_ok;
    assign accept   = s_tvalid && s_tready;

    srle_front #(
        .MAX_REPEATS (MAX_REPEATS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .pixel       (s_tdata),
        .row_end     (s_tlast),
        .image_start (s_tuser),
        .push        (push)
    );

    srle_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (pop),
        .space_ok   (space_ok),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    srle_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_item   (out_item)
    );

    // pack the result fields onto the master stream
    assign m_tdata = {7'd0, out_item.row_overflow, out_item.image_total, out_item.out_byte};
    assign m_tlast = out_item.last;
    assign m_tuser = out_item.is_row_count;

endmodule

`default_nettype wire
